// File: hw/rtl/grid_bilinear_interpolator_defines.svh
// ----------------------------------------------------------------------------
// grid_bilinear_interpolator_defines
// Assertion macros used by the grid interpolator RTL.
// ----------------------------------------------------------------------------
`ifndef GRID_BILINEAR_INTERPOLATOR_DEFINES_SVH
`define GRID_BILINEAR_INTERPOLATOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define GBI_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
`define GBI_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define GBI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define GBI_ASSERT(lbl, expr, msg)
`define GBI_ASSERT_IMPL(lbl, ante, cons, msg)
`define GBI_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: hw/rtl/gbi_pkg.sv
// ----------------------------------------------------------------------------
// gbi_pkg
// Types, constants and command/status structs of the grid interpolator.
// ----------------------------------------------------------------------------
package gbi_pkg;
	localparam int DEF_MAX_COLS = 256;
	localparam int DEF_MAX_ROWS = 256;
	localparam int CFG_W = 32;
	localparam int CFG_IDX_W = 3;
	localparam int VW = 32;
	localparam int AW = 48;
	localparam int SW = 31;
	localparam logic signed [AW-1:0] SAT_LIM = 48'sd1099511627776;

	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_X = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_Y = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COLS = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_UNDEF = 3'd6;

	localparam logic [2:0] RD_LAST = 3'd4;

	typedef enum logic [2:0] {
		OP_IX = 3'd0,
		OP_IY = 3'd1,
		OP_MEAN = 3'd2,
		OP_ZB = 3'd3,
		OP_ZA = 3'd4,
		OP_RES = 3'd5
	} op_t;

	typedef struct packed {
		logic wr;
		logic ld_query;
		logic mdu_start;
		op_t op;
		logic cap;
		logic idx;
		logic node;
		logic rd;
		logic [2:0] rd_k;
		logic check;
		logic out_ld;
	} cmd_t;

	typedef struct packed {
		logic is_query;
		logic mdu_done;
		logic all_undef;
		logic out_full;
	} status_t;
endpackage

// File: hw/rtl/gbi_intf.sv
// ----------------------------------------------------------------------------
// gbi_intf
// Valid/ready channel interfaces for query/write items and results.
// ----------------------------------------------------------------------------
interface gbi_in_if;
	logic valid;
	logic ready;
	logic op;
	logic [7:0] cell_col;
	logic [7:0] cell_row;
	logic signed [31:0] cell_value;
	logic signed [31:0] query_x;
	logic signed [31:0] query_y;
	modport source(output valid, op, cell_col, cell_row, cell_value, query_x, query_y,
		input ready);
	modport sink(input valid, op, cell_col, cell_row, cell_value, query_x, query_y,
		output ready);
endinterface

interface gbi_out_if;
	logic valid;
	logic ready;
	logic signed [31:0] interp_value;
	logic is_undefined;
	modport source(output valid, interp_value, is_undefined, input ready);
	modport sink(input valid, interp_value, is_undefined, output ready);
endinterface

// File: hw/rtl/gbi_mdu.sv
// ----------------------------------------------------------------------------
// gbi_mdu
// Iterative signed floor(a * b / c) unit, shift-add multiply then restoring
// divide, quotient saturated to +/-2^40.
// ----------------------------------------------------------------------------
`include "grid_bilinear_interpolator_defines.svh"
module gbi_mdu (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic signed [gbi_pkg::AW-1:0]  a,
	input  logic signed [gbi_pkg::AW-1:0]  b,
	input  logic [gbi_pkg::SW-1:0]         c,
	output logic                           done,
	output logic signed [gbi_pkg::AW-1:0]  q
);
	import gbi_pkg::*;

	localparam int PW = 2 * AW;
	localparam int QW = 42;
	localparam int CNW = $clog2(QW);

	typedef enum logic [3:0] {
		M_IDLE = 4'b0001,
		M_MUL = 4'b0010,
		M_DIV = 4'b0100,
		M_FIN = 4'b1000
	} mstate_t;

	mstate_t state_q;
	logic neg_q, big_q, done_q;
	logic [PW-1:0] ua_q, acc_q;
	logic [AW-1:0] ub_q;
	logic [SW-1:0] c_q, rem_q;
	logic [QW-1:0] dq_q;
	logic [CNW-1:0] cnt_q;
	logic signed [AW-1:0] q_q;

	logic [AW-1:0] abs_a, abs_b;
	logic [SW:0] t;
	logic ge;
	logic [QW:0] mag;

	always_comb begin
		abs_a = a[AW-1] ? AW'(-a) : AW'(a);
		abs_b = b[AW-1] ? AW'(-b) : AW'(b);
		t = {rem_q, dq_q[QW-1]};
		ge = t >= {1'b0, c_q};
		if (big_q) begin
			mag = (QW+1)'(SAT_LIM) + (QW+1)'(1);
		end else begin
			mag = {1'b0, dq_q} + (QW+1)'(neg_q && (rem_q != '0));
		end
		if (mag > (QW+1)'(SAT_LIM)) begin
			mag = (QW+1)'(SAT_LIM);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				M_IDLE: begin
					if (start) begin
						state_q <= M_MUL;
					end
				end
				M_MUL: begin
					if (ub_q == '0) begin
						state_q <= (acc_q[PW-1:QW] >= (PW-QW)'(c_q)) ? M_FIN : M_DIV;
					end
				end
				M_DIV: begin
					if (cnt_q == '0) begin
						state_q <= M_FIN;
					end
				end
				M_FIN: begin
					done_q <= 1'b1;
					state_q <= M_IDLE;
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			M_IDLE: begin
				if (start) begin
					neg_q <= a[AW-1] ^ b[AW-1];
					ua_q <= PW'(abs_a);
					ub_q <= abs_b;
					acc_q <= '0;
					c_q <= c;
				end
			end
			M_MUL: begin
				if (ub_q == '0) begin
					big_q <= acc_q[PW-1:QW] >= (PW-QW)'(c_q);
					rem_q <= SW'(acc_q[PW-1:QW]);
					dq_q <= acc_q[QW-1:0];
					cnt_q <= CNW'(QW - 1);
				end else begin
					if (ub_q[0]) begin
						acc_q <= acc_q + ua_q;
					end
					ua_q <= ua_q << 1;
					ub_q <= ub_q >> 1;
				end
			end
			M_DIV: begin
				rem_q <= ge ? SW'(t - {1'b0, c_q}) : SW'(t);
				dq_q <= {dq_q[QW-2:0], ge};
				cnt_q <= cnt_q - CNW'(1);
			end
			M_FIN: begin
				q_q <= neg_q ? -AW'(mag) : AW'(mag);
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign q = q_q;

	`GBI_ASSERT_IMPL(a_rem_below_div, state_q == M_DIV, rem_q < c_q, "remainder not below divisor")
	`GBI_ASSERT_IMPL(a_q_saturated, done_q, (q_q <= SAT_LIM) && (q_q >= -SAT_LIM), "quotient beyond limit")
	`GBI_ASSERT_NEXT(a_mul_exit, state_q == M_MUL, (state_q == M_MUL) || (state_q == M_DIV) || (state_q == M_FIN), "bad exit from multiply")
endmodule

// File: hw/rtl/gbi_ctrl.sv
// ----------------------------------------------------------------------------
// gbi_ctrl
// Sequencer for writes and queries: index divides, corner reads, mean and
// the three interpolation steps.
// ----------------------------------------------------------------------------
module gbi_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  gbi_pkg::status_t  status,
	output gbi_pkg::cmd_t     cmd
);
	import gbi_pkg::*;

	typedef enum logic [7:0] {
		C_IDLE = 8'b00000001,
		C_LAUNCH = 8'b00000010,
		C_WAIT = 8'b00000100,
		C_INDEX = 8'b00001000,
		C_NODE = 8'b00010000,
		C_READ = 8'b00100000,
		C_CHECK = 8'b01000000,
		C_OUT = 8'b10000000
	} cstate_t;

	cstate_t state_q, state_d;
	op_t op_q, op_d;
	logic [2:0] rd_k_q, rd_k_d;

	always_comb begin
		state_d = state_q;
		op_d = op_q;
		rd_k_d = rd_k_q;
		cmd = '0;
		cmd.op = op_q;
		cmd.rd_k = rd_k_q;
		in_ready = 1'b0;
		case (state_q)
			C_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (status.is_query) begin
						cmd.ld_query = 1'b1;
						op_d = OP_IX;
						state_d = C_LAUNCH;
					end else begin
						cmd.wr = 1'b1;
					end
				end
			end
			C_LAUNCH: begin
				cmd.mdu_start = 1'b1;
				state_d = C_WAIT;
			end
			C_WAIT: begin
				if (status.mdu_done) begin
					cmd.cap = 1'b1;
					case (op_q)
						OP_IX: begin
							op_d = OP_IY;
							state_d = C_LAUNCH;
						end
						OP_IY: state_d = C_INDEX;
						OP_MEAN: begin
							op_d = OP_ZB;
							state_d = C_LAUNCH;
						end
						OP_ZB: begin
							op_d = OP_ZA;
							state_d = C_LAUNCH;
						end
						OP_ZA: begin
							op_d = OP_RES;
							state_d = C_LAUNCH;
						end
						OP_RES: state_d = C_OUT;
						default: state_d = C_IDLE;
					endcase
				end
			end
			C_INDEX: begin
				cmd.idx = 1'b1;
				state_d = C_NODE;
			end
			C_NODE: begin
				cmd.node = 1'b1;
				rd_k_d = '0;
				state_d = C_READ;
			end
			C_READ: begin
				cmd.rd = 1'b1;
				if (rd_k_q == RD_LAST) begin
					state_d = C_CHECK;
				end else begin
					rd_k_d = rd_k_q + 3'd1;
				end
			end
			C_CHECK: begin
				cmd.check = 1'b1;
				if (status.all_undef) begin
					state_d = C_OUT;
				end else begin
					op_d = OP_MEAN;
					state_d = C_LAUNCH;
				end
			end
			C_OUT: begin
				if (!status.out_full) begin
					cmd.out_ld = 1'b1;
					state_d = C_IDLE;
				end
			end
			default: state_d = C_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			op_q <= OP_IX;
			rd_k_q <= '0;
		end else begin
			state_q <= state_d;
			op_q <= op_d;
			rd_k_q <= rd_k_d;
		end
	end
endmodule

// File: hw/rtl/gbi_dpath.sv
// ----------------------------------------------------------------------------
// gbi_dpath
// Configuration registers, grid memory, index and offset logic, corner
// registers, shared multiply-divide unit and result register.
// ----------------------------------------------------------------------------
module gbi_dpath #(
	parameter int MaxCols = gbi_pkg::DEF_MAX_COLS,
	parameter int MaxRows = gbi_pkg::DEF_MAX_ROWS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [gbi_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [gbi_pkg::CFG_W-1:0]        cfg_data,
	input  logic                             op,
	input  logic [7:0]                       cell_col,
	input  logic [7:0]                       cell_row,
	input  logic signed [31:0]               cell_value,
	input  logic signed [31:0]               query_x,
	input  logic signed [31:0]               query_y,
	input  gbi_pkg::cmd_t                    cmd,
	output gbi_pkg::status_t                 status,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [31:0]               interp_value,
	output logic                             is_undefined
);
	import gbi_pkg::*;

	localparam int CW = (MaxCols > 1) ? $clog2(MaxCols) : 1;
	localparam int RW = (MaxRows > 1) ? $clog2(MaxRows) : 1;
	localparam int DEPTH = MaxCols * MaxRows;
	localparam int AD = $clog2(DEPTH);
	localparam logic [15:0] MC16 = 16'(MaxCols);
	localparam logic [15:0] MR16 = 16'(MaxRows);

	logic signed [31:0] ox_q, oy_q, undef_q;
	logic [SW-1:0] sx_q, sy_q;
	logic [8:0] cols_q, rows_q;
	logic signed [31:0] qx_q, qy_q;
	logic signed [AW-1:0] ix_q, iy_q, dx_q, dy_q, zb_q, za_q;
	logic [CW-1:0] i0_q, i1_q;
	logic [RW-1:0] j0_q, j1_q;
	logic signed [31:0] z_q [4];
	logic signed [31:0] rdata_q, res_q, out_val_q;
	logic und_q, out_und_q, out_valid_q;
	logic [31:0] mem [DEPTH];

	logic [SW-1:0] sxe, sye;
	logic [15:0] cq, rq, col_max, row_max;
	logic signed [AW-1:0] dqx, dqy;
	logic [CW+30:0] px;
	logic [RW+30:0] py;
	logic [3:0] def;
	logic signed [34:0] sum;
	logic [2:0] cnt;
	logic [CW-1:0] rd_i;
	logic [RW-1:0] rd_j;
	logic [AD-1:0] rd_addr, wr_addr;
	logic wr_ok;
	logic mdu_done;
	logic signed [AW-1:0] mdu_a, mdu_b, mdu_q;
	logic [SW-1:0] mdu_c;

	function automatic logic [15:0] clampi(input logic signed [AW-1:0] v,
		input logic [15:0] mx);
		if (v < 0) begin
			return 16'd0;
		end else if (v > $signed({32'd0, mx})) begin
			return mx;
		end
		return v[15:0];
	endfunction

	function automatic logic signed [AW-1:0] sat40(input logic signed [AW-1:0] v);
		if (v > SAT_LIM) begin
			return SAT_LIM;
		end else if (v < -SAT_LIM) begin
			return -SAT_LIM;
		end
		return v;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [AW-1:0] v);
		if (v > 48'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -48'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	always_comb begin
		sxe = (sx_q == '0) ? SW'(1) : sx_q;
		sye = (sy_q == '0) ? SW'(1) : sy_q;
		cq = (cols_q == '0) ? 16'd1 : ((16'(cols_q) > MC16) ? MC16 : 16'(cols_q));
		rq = (rows_q == '0) ? 16'd1 : ((16'(rows_q) > MR16) ? MR16 : 16'(rows_q));
		col_max = cq - 16'd1;
		row_max = rq - 16'd1;
		dqx = AW'(qx_q) - AW'(ox_q);
		dqy = AW'(qy_q) - AW'(oy_q);
		px = (CW+31)'(i0_q) * (CW+31)'(sxe);
		py = (RW+31)'(j0_q) * (RW+31)'(sye);
		sum = '0;
		cnt = '0;
		for (int k = 0; k < 4; k++) begin
			def[k] = z_q[k] != undef_q;
			if (def[k]) begin
				sum = sum + 35'(z_q[k]);
				cnt = cnt + 3'd1;
			end
		end
		case (cmd.rd_k)
			3'd0: begin
				rd_i = i0_q;
				rd_j = j0_q;
			end
			3'd1: begin
				rd_i = i1_q;
				rd_j = j0_q;
			end
			3'd2: begin
				rd_i = i1_q;
				rd_j = j1_q;
			end
			default: begin
				rd_i = i0_q;
				rd_j = j1_q;
			end
		endcase
		rd_addr = AD'(AD'(rd_j) * AD'(MaxCols) + AD'(rd_i));
		wr_addr = AD'(AD'(cell_row) * AD'(MaxCols) + AD'(cell_col));
		wr_ok = (16'(cell_col) < MC16) && (16'(cell_row) < MR16);
		mdu_b = AW'(1);
		case (cmd.op)
			OP_IX: begin
				mdu_a = dqx;
				mdu_c = sxe;
			end
			OP_IY: begin
				mdu_a = dqy;
				mdu_c = sye;
			end
			OP_MEAN: begin
				mdu_a = AW'(sum);
				mdu_c = SW'(cnt);
			end
			OP_ZB: begin
				mdu_a = AW'(z_q[2]) - AW'(z_q[1]);
				mdu_b = dy_q;
				mdu_c = sye;
			end
			OP_ZA: begin
				mdu_a = AW'(z_q[3]) - AW'(z_q[0]);
				mdu_b = dy_q;
				mdu_c = sye;
			end
			OP_RES: begin
				mdu_a = zb_q - za_q;
				mdu_b = dx_q;
				mdu_c = sxe;
			end
			default: begin
				mdu_a = '0;
				mdu_c = SW'(1);
			end
		endcase
	end

	gbi_mdu u_mdu (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mdu_start),
		.a      (mdu_a),
		.b      (mdu_b),
		.c      (mdu_c),
		.done   (mdu_done),
		.q      (mdu_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ox_q <= '0;
			oy_q <= '0;
			sx_q <= SW'(65536);
			sy_q <= SW'(65536);
			cols_q <= 9'd256;
			rows_q <= 9'd256;
			undef_q <= 32'sh7fffffff;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_ORIGIN_X: ox_q <= cfg_data;
					REG_ORIGIN_Y: oy_q <= cfg_data;
					REG_STEP_X: sx_q <= cfg_data[SW-1:0];
					REG_STEP_Y: sy_q <= cfg_data[SW-1:0];
					REG_COLS: cols_q <= cfg_data[8:0];
					REG_ROWS: rows_q <= cfg_data[8:0];
					REG_UNDEF: undef_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.out_ld) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr && wr_ok) begin
			mem[wr_addr] <= cell_value;
		end
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_query) begin
			qx_q <= query_x;
			qy_q <= query_y;
		end
		if (cmd.idx) begin
			i0_q <= CW'(clampi(ix_q, col_max));
			i1_q <= CW'(clampi(ix_q + AW'(1), col_max));
			j0_q <= RW'(clampi(iy_q, row_max));
			j1_q <= RW'(clampi(iy_q + AW'(1), row_max));
		end
		if (cmd.node) begin
			dx_q <= dqx - $signed(AW'(px));
			dy_q <= dqy - $signed(AW'(py));
		end
		if (cmd.rd && (cmd.rd_k != 3'd0)) begin
			z_q[2'(cmd.rd_k - 3'd1)] <= rdata_q;
		end
		if (cmd.check && (def == 4'd0)) begin
			res_q <= undef_q;
			und_q <= 1'b1;
		end
		if (cmd.cap) begin
			case (cmd.op)
				OP_IX: ix_q <= mdu_q;
				OP_IY: iy_q <= mdu_q;
				OP_MEAN: begin
					for (int k = 0; k < 4; k++) begin
						if (!def[k]) begin
							z_q[k] <= mdu_q[31:0];
						end
					end
				end
				OP_ZB: zb_q <= sat40(mdu_q + AW'(z_q[1]));
				OP_ZA: za_q <= sat40(mdu_q + AW'(z_q[0]));
				OP_RES: begin
					res_q <= sat32(mdu_q + za_q);
					und_q <= 1'b0;
				end
				default: ;
			endcase
		end
		if (cmd.out_ld) begin
			out_val_q <= res_q;
			out_und_q <= und_q;
		end
	end

	assign status.is_query = op;
	assign status.mdu_done = mdu_done;
	assign status.all_undef = def == 4'd0;
	assign status.out_full = out_valid_q;
	assign out_valid = out_valid_q;
	assign interp_value = out_val_q;
	assign is_undefined = out_und_q;
endmodule

// File: hw/rtl/grid_bilinear_interpolator.sv
// ----------------------------------------------------------------------------
// grid_bilinear_interpolator
// Grid store with bilinear point queries in Q16.16.
// ----------------------------------------------------------------------------
// in_ch carries write items (op = 0, one cell stored) and queries (op = 1).
// A write is taken while idle and gives no transaction on out_ch.
// A query gives one out_ch transaction: the interpolated value, or the
// undefined code with is_undefined set when all four corners are undefined.
// Items are handled one at a time; in_ch.ready is high only while idle.
// Queries use the shared iterative multiply-divide unit, which runs two
// index divides and, unless all four corners are undefined, the mean and
// three interpolation steps, one op at a time. Each multiply ends once the
// multiplier has shifted out, and the restoring divide is skipped when the
// quotient overflows.
// A finished result sits in the output register; a stalled receiver holds it
// there and the block waits before loading the next one.
// Configuration writes through cfg_wr_en/cfg_index/cfg_data take effect at
// once; users make them only while the block is idle, which it does not check.
// Reset restores the register defaults; grid contents are undefined until
// written and the memory needs no clearing pass.
// ----------------------------------------------------------------------------
module grid_bilinear_interpolator #(
	parameter int MaxCols = gbi_pkg::DEF_MAX_COLS,
	parameter int MaxRows = gbi_pkg::DEF_MAX_ROWS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	gbi_in_if.sink                         in_ch,
	gbi_out_if.source                      out_ch,
	input  logic                           cfg_wr_en,
	input  logic [gbi_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gbi_pkg::CFG_W-1:0]      cfg_data
);
	import gbi_pkg::*;

	cmd_t cmd;
	status_t status;
	logic in_ready;

	gbi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	gbi_dpath #(
		.MaxCols (MaxCols),
		.MaxRows (MaxRows)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.op           (in_ch.op),
		.cell_col     (in_ch.cell_col),
		.cell_row     (in_ch.cell_row),
		.cell_value   (in_ch.cell_value),
		.query_x      (in_ch.query_x),
		.query_y      (in_ch.query_y),
		.cmd          (cmd),
		.status       (status),
		.out_valid    (out_ch.valid),
		.out_ready    (out_ch.ready),
		.interp_value (out_ch.interp_value),
		.is_undefined (out_ch.is_undefined)
	);

	assign in_ch.ready = in_ready;
endmodule
